[rtl/core/pes_pkg.sv]
// ----------------------------------------------------------------------------
// pes_pkg
// Shared constants and types for the prime element sum block.
// ----------------------------------------------------------------------------
package pes_pkg;

  localparam int VALUE_BITS_DEF = 16;
  localparam int SUM_BITS_DEF   = 24;

  // status of the serial remainder unit
  typedef struct packed {
    logic busy;
    logic done;
    logic rem_zero;
  } div_status_t;

endpackage

[rtl/core/pes_divider.sv]
// ----------------------------------------------------------------------------
// pes_divider
// Bit-serial restoring remainder unit: one dividend bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module pes_divider #(
  parameter int VALUE_BITS = pes_pkg::VALUE_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [VALUE_BITS-1:0]   dividend_i,
  input  logic [VALUE_BITS-1:0]   divisor_i,
  output pes_pkg::div_status_t    status_o
);
  import pes_pkg::*;

  localparam int CntBits = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] n_q, n_d;
  logic [VALUE_BITS:0]   r_q, r_d;
  logic [CntBits-1:0]    cnt_q, cnt_d;
  logic                  done_q, done_d;
  logic [VALUE_BITS:0]   r_shift;

  always_comb begin
    r_shift = {r_q[VALUE_BITS-1:0], n_q[VALUE_BITS-1]};
    n_d     = n_q;
    r_d     = r_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    if (start_i) begin
      n_d   = dividend_i;
      r_d   = '0;
      cnt_d = CntBits'(VALUE_BITS);
    end else if (cnt_q != '0) begin
      // shift in the next dividend bit, subtract when it fits
      n_d = {n_q[VALUE_BITS-2:0], 1'b0};
      if (r_shift >= {1'b0, divisor_i}) begin
        r_d = r_shift - {1'b0, divisor_i};
      end else begin
        r_d = r_shift;
      end
      cnt_d  = cnt_q - CntBits'(1);
      done_d = (cnt_q == CntBits'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d;
    r_q <= r_d;
  end

  assign status_o.busy     = (cnt_q != '0);
  assign status_o.done     = done_q;
  assign status_o.rem_zero = (r_q == '0);

endmodule

[rtl/core/pes_accum.sv]
// ----------------------------------------------------------------------------
// pes_accum
// Saturating running total of prime elements, cleared after the last word.
// ----------------------------------------------------------------------------
module pes_accum #(
  parameter int VALUE_BITS = pes_pkg::VALUE_BITS_DEF,
  parameter int SUM_BITS   = pes_pkg::SUM_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  update_i,
  input  logic                  prime_i,
  input  logic                  last_i,
  input  logic [VALUE_BITS-1:0] addend_i,
  output logic [SUM_BITS-1:0]   sum_o
);
  import pes_pkg::*;

  localparam int WideBits = ((SUM_BITS > VALUE_BITS) ? SUM_BITS : VALUE_BITS) + 1;
  localparam logic [WideBits-1:0] SumMax = {{(WideBits-SUM_BITS){1'b0}}, {SUM_BITS{1'b1}}};

  logic [SUM_BITS-1:0] total_q, total_d;
  logic [WideBits-1:0] wide_sum;

  always_comb begin
    wide_sum = WideBits'(total_q) + WideBits'(addend_i);
    sum_o    = total_q;
    if (prime_i) begin
      // clamp at the top of the range
      if (wide_sum >= SumMax) begin
        sum_o = {SUM_BITS{1'b1}};
      end else begin
        sum_o = wide_sum[SUM_BITS-1:0];
      end
    end
    total_d = total_q;
    if (update_i) begin
      total_d = last_i ? '0 : sum_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else begin
      total_q <= total_d;
    end
  end

endmodule

[rtl/core/prime_element_sum.sv]
// ----------------------------------------------------------------------------
// prime_element_sum
// Trial-division primality test per matrix element with a saturating sum.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i / in_stall_o carry one element word (value_i,
//   last_element_i). Output channel: out_valid_o / out_stall_i carry one
//   result word (is_prime_o, running_sum_o, last_out_o) per input word.
//   Values at or below one go straight to the done state as not prime.
//   Otherwise divisors d = 2, 3, ... are tried while d*d <= value; each
//   trial runs in the bit-serial remainder unit. A composite stops at its
//   smallest factor. One word is in flight at a time; in_stall_o is high
//   from accept until its result has been loaded into the output register.
//   A finished result waits in the output register while out_stall_i is
//   high; the next input word may be accepted meanwhile, and its result
//   holds in the core until the register frees.
//   Reset clears the running total, the control and the output valid.
//   After a word with last_element_i set, the total restarts from zero.
// ----------------------------------------------------------------------------
module prime_element_sum #(
  parameter int VALUE_BITS = pes_pkg::VALUE_BITS_DEF,
  parameter int SUM_BITS   = pes_pkg::SUM_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [VALUE_BITS-1:0] value_i,
  input  logic                         last_element_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         is_prime_o,
  output logic [SUM_BITS-1:0]          running_sum_o,
  output logic                         last_out_o
);
  import pes_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e                state_q, state_d;
  logic [VALUE_BITS-1:0] n_q, n_d;
  logic [VALUE_BITS-1:0] div_q, div_d;
  logic [VALUE_BITS:0]   sq_q, sq_d;
  logic                  prime_q, prime_d;
  logic                  last_q, last_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_prime_q, out_last_q;
  logic [SUM_BITS-1:0]   out_sum_q;
  logic                  in_accept, out_load, div_start, gt_one;
  logic [SUM_BITS-1:0]   sum_next;
  div_status_t           div_status;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign gt_one     = !value_i[VALUE_BITS-1] &&
                      (value_i[VALUE_BITS-2:0] > (VALUE_BITS-1)'(1));
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    div_d     = div_q;
    sq_d      = sq_q;
    prime_d   = prime_q;
    last_d    = last_q;
    div_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          n_d     = value_i;
          last_d  = last_element_i;
          div_d   = VALUE_BITS'(2);
          sq_d    = (VALUE_BITS+1)'(4);
          prime_d = 1'b0;
          state_d = gt_one ? ST_CHECK : ST_DONE;
        end
      end
      ST_CHECK: begin
        if (sq_q > {1'b0, n_q}) begin
          prime_d = 1'b1;
          state_d = ST_DONE;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_status.done) begin
          if (div_status.rem_zero) begin
            state_d = ST_DONE;
          end else begin
            // advance: (d+1)^2 = d^2 + 2d + 1
            div_d   = div_q + VALUE_BITS'(1);
            sq_d    = sq_q + {div_q, 1'b1};
            state_d = ST_CHECK;
          end
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  pes_divider #(
    .VALUE_BITS(VALUE_BITS)
  ) u_divider (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(n_q),
    .divisor_i (div_q),
    .status_o  (div_status)
  );

  pes_accum #(
    .VALUE_BITS(VALUE_BITS),
    .SUM_BITS  (SUM_BITS)
  ) u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .update_i(out_load),
    .prime_i (prime_q),
    .last_i  (last_q),
    .addend_i(n_q),
    .sum_o   (sum_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    div_q   <= div_d;
    sq_q    <= sq_d;
    prime_q <= prime_d;
    last_q  <= last_d;
    if (out_load) begin
      out_prime_q <= prime_q;
      out_sum_q   <= sum_next;
      out_last_q  <= last_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign is_prime_o    = out_prime_q;
  assign running_sum_o = out_sum_q;
  assign last_out_o    = out_last_q;

endmodule
